### rtl/wtsa_pkg.sv
package wtsa_pkg;

    localparam int STATIONS  = 16;
    localparam int TIDS      = 16;
    localparam int SEQ_W     = 12;
    localparam int TID_W     = 4;
    localparam int ADDR_W    = 48;
    localparam int FUNC_W    = 2;
    localparam int GROUP_BIT = 40;
    localparam int STA_W     = (STATIONS > 1) ? $clog2(STATIONS) : 1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef logic [TIDS-1:0][SEQ_W-1:0] row_t;

endpackage

### rtl/wtsa_req_if.sv
interface wtsa_req_if;

    logic                             valid;
    logic                             ready;
    logic [wtsa_pkg::FUNC_W-1:0]      func;
    logic                             is_qos_data;
    logic [wtsa_pkg::ADDR_W-1:0]      dest_addr;
    logic [wtsa_pkg::TID_W-1:0]       tid;

    modport source
    (
        output valid,
        output func,
        output is_qos_data,
        output dest_addr,
        output tid,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  is_qos_data,
        input  dest_addr,
        input  tid,
        output ready
    );

endinterface

### rtl/wtsa_rsp_if.sv
interface wtsa_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [wtsa_pkg::SEQ_W-1:0]  seq_num;
    logic                        table_full;

    modport source
    (
        output valid,
        output seq_num,
        output table_full,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  seq_num,
        input  table_full,
        output ready
    );

endinterface

### rtl/wifi_tx_sequence_allocator_core.sv
// Transmit sequence number allocator. Takes one request word per cycle and
// returns one response word per request, in order. The path is three
// registers deep (input register, row read register, response register);
// the depth is set by the registered read of the per-station counter memory,
// which holds one row of sixteen 12-bit counters per station. Allocate and
// peek for individually addressed QoS data frames use the station table
// (parallel address compare over all entries), other allocates and peeks
// use the shared counter, and a query always reads the station table.
// An allocate for an unknown station takes the lowest free entry; when none is
// free the response carries table_full with sequence number 0 and nothing is
// stored. The pipeline stalls as a whole while a response waits to be taken.
module wifi_tx_sequence_allocator_core
(
    input  logic              clk,
    input  logic              rst_n,
    wtsa_req_if.sink          req,
    wtsa_rsp_if.source        rsp
);

    logic                              adv;

    logic                              a_valid_reg;
    logic [wtsa_pkg::FUNC_W-1:0]       a_func_reg;
    logic                              a_qos_reg;
    logic [wtsa_pkg::ADDR_W-1:0]       a_addr_reg;
    logic [wtsa_pkg::TID_W-1:0]        a_tid_reg;

    logic [wtsa_pkg::SEQ_W-1:0]        shared_reg;
    logic [wtsa_pkg::SEQ_W-1:0]        shared_next;
    logic [wtsa_pkg::STATIONS-1:0]     sta_valid_reg;
    logic [wtsa_pkg::ADDR_W-1:0]       sta_addr_reg [wtsa_pkg::STATIONS];

    logic                              b_valid_reg;
    logic                              b_use_row_reg;
    logic                              b_insert_reg;
    logic                              b_inc_reg;
    logic [wtsa_pkg::TID_W-1:0]        b_tid_reg;
    logic [wtsa_pkg::STA_W-1:0]        b_idx_reg;
    logic [wtsa_pkg::SEQ_W-1:0]        b_seq_reg;
    logic                              b_full_reg;

    wtsa_pkg::row_t                    row_mem [wtsa_pkg::STATIONS];
    wtsa_pkg::row_t                    rd_row_reg;

    logic                              out_valid_reg;
    logic [wtsa_pkg::SEQ_W-1:0]        out_seq_reg;
    logic                              out_full_reg;

    logic                              is_alloc;
    logic                              is_peek;
    logic                              is_query;
    logic                              indiv_qos;
    logic                              hit;
    logic [wtsa_pkg::STA_W-1:0]        hit_idx;
    logic                              free_any;
    logic [wtsa_pkg::STA_W-1:0]        free_idx;
    logic                              use_row;
    logic                              do_insert;
    logic                              do_full;
    logic                              shared_path;

    logic [wtsa_pkg::SEQ_W-1:0]        cur_cnt;
    logic [wtsa_pkg::SEQ_W-1:0]        seq_out;
    wtsa_pkg::row_t                    wr_row;
    logic                              wr_en;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    assign rsp.valid      = out_valid_reg;
    assign rsp.seq_num    = out_seq_reg;
    assign rsp.table_full = out_full_reg;

    // station lookup and decision
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = wtsa_pkg::STATIONS - 1; s >= 0; s--)
        begin
            if (sta_valid_reg[s] && (sta_addr_reg[s] == a_addr_reg))
            begin
                hit     = 1'b1;
                hit_idx = wtsa_pkg::STA_W'(s);
            end
            if (!sta_valid_reg[s])
            begin
                free_any = 1'b1;
                free_idx = wtsa_pkg::STA_W'(s);
            end
        end
    end

    assign is_alloc    = (a_func_reg == wtsa_pkg::FUNC_ALLOC);
    assign is_peek     = (a_func_reg == wtsa_pkg::FUNC_PEEK);
    assign is_query    = (a_func_reg == wtsa_pkg::FUNC_QUERY);
    assign indiv_qos   = a_qos_reg && !a_addr_reg[wtsa_pkg::GROUP_BIT];
    assign use_row     = hit && (is_query || ((is_alloc || is_peek) && indiv_qos));
    assign do_insert   = is_alloc && indiv_qos && !hit && free_any;
    assign do_full     = is_alloc && indiv_qos && !hit && !free_any;
    assign shared_path = (is_alloc || is_peek) && !indiv_qos;

    assign shared_next = (adv && a_valid_reg && shared_path && is_alloc)
                       ? shared_reg + wtsa_pkg::SEQ_W'(1) : shared_reg;

    // counter update and response value
    always_comb
    begin
        cur_cnt = rd_row_reg[b_tid_reg];
        seq_out = b_use_row_reg ? cur_cnt : b_seq_reg;
        if (b_insert_reg)
        begin
            wr_row            = '0;
            wr_row[b_tid_reg] = wtsa_pkg::SEQ_W'(1);
        end
        else
        begin
            wr_row            = rd_row_reg;
            wr_row[b_tid_reg] = cur_cnt + wtsa_pkg::SEQ_W'(1);
        end
    end

    assign wr_en = adv && b_valid_reg && (b_insert_reg || (b_use_row_reg && b_inc_reg));

    // counter rows; forward a row written in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[b_idx_reg] <= wr_row;
        end
        if (adv)
        begin
            if (wr_en && (b_idx_reg == hit_idx))
            begin
                rd_row_reg <= wr_row;
            end
            else
            begin
                rd_row_reg <= row_mem[hit_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            shared_reg    <= '0;
            sta_valid_reg <= '0;
        end
        else
        begin
            shared_reg <= shared_next;
            if (adv)
            begin
                a_valid_reg   <= req.valid;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
                if (a_valid_reg && do_insert)
                begin
                    sta_valid_reg[free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (req.valid)
            begin
                a_func_reg <= req.func;
                a_qos_reg  <= req.is_qos_data;
                a_addr_reg <= req.dest_addr;
                a_tid_reg  <= req.tid;
            end
            if (a_valid_reg && do_insert)
            begin
                sta_addr_reg[free_idx] <= a_addr_reg;
            end
            b_use_row_reg <= use_row;
            b_insert_reg  <= do_insert;
            b_inc_reg     <= is_alloc;
            b_tid_reg     <= a_tid_reg;
            b_idx_reg     <= do_insert ? free_idx : hit_idx;
            b_seq_reg     <= shared_path ? shared_reg : '0;
            b_full_reg    <= do_full;
            out_seq_reg   <= seq_out;
            out_full_reg  <= b_full_reg;
        end
    end

endmodule

### bench/wifi_tx_sequence_allocator_core_tb.sv
`timescale 1ns / 1ps

module wifi_tx_sequence_allocator_core_tb;

    localparam logic [wtsa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_WORDS   = 400;
    localparam int POOL_SIZE      = 20;
    localparam int COUNT_RUN      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [wtsa_pkg::ADDR_W-1:0] ADDR_STA_A   = 48'h0200_0000_0011;
    localparam logic [wtsa_pkg::ADDR_W-1:0] ADDR_ZERO    = 48'h0000_0000_0000;
    localparam logic [wtsa_pkg::ADDR_W-1:0] ADDR_TOP_IND = 48'hFEFF_FFFF_FFFF;
    localparam logic [wtsa_pkg::ADDR_W-1:0] ADDR_ONES    = 48'hFFFF_FFFF_FFFF;
    localparam logic [wtsa_pkg::ADDR_W-1:0] ADDR_GROUP   = 48'h0100_5E00_0001;

    typedef struct packed {
        logic [wtsa_pkg::FUNC_W-1:0] func;
        logic                        qos;
        logic [wtsa_pkg::ADDR_W-1:0] addr;
        logic [wtsa_pkg::TID_W-1:0]  tid;
    } frame_t;

    typedef struct packed {
        logic [wtsa_pkg::SEQ_W-1:0] seq;
        logic                       full;
    } seq_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wtsa_req_if req_bus ();
    wtsa_rsp_if rsp_bus ();

    wifi_tx_sequence_allocator_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    logic [wtsa_pkg::SEQ_W-1:0]  shared_next;
    logic                        sta_used [wtsa_pkg::STATIONS];
    logic [wtsa_pkg::ADDR_W-1:0] sta_addr [wtsa_pkg::STATIONS];
    logic [wtsa_pkg::SEQ_W-1:0]  sta_next [wtsa_pkg::STATIONS][wtsa_pkg::TIDS];

    seq_result_t expected_numbers[$];
    seq_result_t got_result;
    seq_result_t want_result;

    int  mismatches = 0;
    int  words_sent = 0;
    int  responses_seen = 0;
    int  full_seen = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  no_gaps = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pause_length();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic frame_t mk_frame(logic [wtsa_pkg::FUNC_W-1:0] func, logic qos,
                                        logic [wtsa_pkg::ADDR_W-1:0] addr,
                                        logic [wtsa_pkg::TID_W-1:0] tid);
        frame_t f;
        f.func = func;
        f.qos  = qos;
        f.addr = addr;
        f.tid  = tid;
        return f;
    endfunction

    function automatic int station_of(logic [wtsa_pkg::ADDR_W-1:0] addr);
        for (int s = 0; s < wtsa_pkg::STATIONS; s++)
            if (sta_used[s] && sta_addr[s] == addr)
                return s;
        return -1;
    endfunction

    function automatic seq_result_t predict_sequence(frame_t f);
        seq_result_t r;
        int s;
        r.seq  = '0;
        r.full = 1'b0;
        case (f.func)
            wtsa_pkg::FUNC_ALLOC, wtsa_pkg::FUNC_PEEK:
            begin
                if (f.qos && !f.addr[wtsa_pkg::GROUP_BIT])
                begin
                    s = station_of(f.addr);
                    if (s >= 0)
                    begin
                        r.seq = sta_next[s][f.tid];
                        if (f.func == wtsa_pkg::FUNC_ALLOC)
                            sta_next[s][f.tid] = r.seq + wtsa_pkg::SEQ_W'(1);
                    end
                    else if (f.func == wtsa_pkg::FUNC_ALLOC)
                    begin
                        for (s = 0; s < wtsa_pkg::STATIONS; s++)
                            if (!sta_used[s])
                                break;
                        if (s < wtsa_pkg::STATIONS)
                        begin
                            sta_used[s] = 1'b1;
                            sta_addr[s] = f.addr;
                            for (int k = 0; k < wtsa_pkg::TIDS; k++)
                                sta_next[s][k] = '0;
                            sta_next[s][f.tid] = wtsa_pkg::SEQ_W'(1);
                        end
                        else
                            r.full = 1'b1;
                    end
                end
                else
                begin
                    r.seq = shared_next;
                    if (f.func == wtsa_pkg::FUNC_ALLOC)
                        shared_next = shared_next + wtsa_pkg::SEQ_W'(1);
                end
            end
            wtsa_pkg::FUNC_QUERY:
            begin
                s = station_of(f.addr);
                if (s >= 0)
                    r.seq = sta_next[s][f.tid];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(frame_t f);
        int gap;
        gap = pause_length();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.func        <= f.func;
        req_bus.is_qos_data <= f.qos;
        req_bus.dest_addr   <= f.addr;
        req_bus.tid         <= f.tid;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        expected_numbers.push_back(predict_sequence(f));
        words_sent++;
    endtask

    task automatic test_shared_counter();
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b0, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b0, ADDR_STA_A, 4'd15));
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b0, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_GROUP, 4'd3));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_ONES, 4'd15));
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b1, ADDR_GROUP, 4'd0));
    endtask

    task automatic test_station_table();
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b1, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_QUERY, 1'b0, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_STA_A, 4'd15));
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b1, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_QUERY, 1'b0, ADDR_STA_A, 4'd0));
        send_word(mk_frame(wtsa_pkg::FUNC_QUERY, 1'b1, ADDR_STA_A, 4'd15));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_ZERO, 4'd5));
        send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_TOP_IND, 4'd9));
        send_word(mk_frame(wtsa_pkg::FUNC_QUERY, 1'b0, ADDR_TOP_IND, 4'd9));
        send_word(mk_frame(wtsa_pkg::FUNC_QUERY, 1'b1, ADDR_GROUP, 4'd0));
        send_word(mk_frame(FUNC_UNUSED, 1'b1, ADDR_STA_A, 4'd0));
        send_word(mk_frame(FUNC_UNUSED, 1'b0, ADDR_ONES, 4'd15));
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b1, ADDR_STA_A, 4'd0));
    endtask

    task automatic test_counter_run();
        for (int i = 0; i < COUNT_RUN; i++)
        begin
            send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b1, ADDR_STA_A, 4'd7));
            send_word(mk_frame(wtsa_pkg::FUNC_ALLOC, 1'b0, ADDR_ZERO, 4'd7));
        end
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b1, ADDR_STA_A, 4'd7));
        send_word(mk_frame(wtsa_pkg::FUNC_PEEK, 1'b0, ADDR_ZERO, 4'd7));
    endtask

    task automatic test_random_traffic();
        logic [wtsa_pkg::ADDR_W-1:0] pool [POOL_SIZE];
        logic [wtsa_pkg::ADDR_W-1:0] addr;
        frame_t f;
        int r;
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            addr[47:32] = 16'($urandom);
            addr[31:0]  = $urandom;
            addr[wtsa_pkg::GROUP_BIT] = 1'b0;
            pool[p] = addr;
        end
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            no_gaps = (i >= 200 && i < 300);
            if ($urandom_range(0, 99) < 80)
            begin
                r = $urandom_range(0, 9);
                f.func = (r < 6) ? wtsa_pkg::FUNC_ALLOC
                       : (r < 8) ? wtsa_pkg::FUNC_PEEK : wtsa_pkg::FUNC_QUERY;
                f.qos  = ($urandom_range(0, 9) != 0);
                f.addr = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else
            begin
                f.func = wtsa_pkg::FUNC_W'($urandom_range(0, 3));
                f.qos  = 1'($urandom_range(0, 1));
                f.addr[47:32] = 16'($urandom);
                f.addr[31:0]  = $urandom;
            end
            f.tid = wtsa_pkg::TID_W'($urandom_range(0, wtsa_pkg::TIDS - 1));
            send_word(f);
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            got_result.seq  = rsp_bus.seq_num;
            got_result.full = rsp_bus.table_full;
            responses_seen++;
            if (got_result.full)
                full_seen++;
            if (expected_numbers.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: seq_num %0d table_full %0b",
                             got_result.seq, got_result.full);
                mismatches++;
            end
            else
            begin
                want_result = expected_numbers.pop_front();
                if (got_result.seq !== want_result.seq
                    || got_result.full !== want_result.full)
                begin
                    if (mismatches < 10)
                        $display("word %0d: seq_num exp %0d got %0d, table_full exp %0b got %0b",
                                 responses_seen, want_result.seq, got_result.seq,
                                 want_result.full, got_result.full);
                    mismatches++;
                end
            end
        end
        if (no_gaps)
            rsp_bus.ready <= 1'b1;
        else if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            hold_left = pause_length();
            rsp_bus.ready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
                || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        req_bus.valid       = 1'b0;
        req_bus.func        = wtsa_pkg::FUNC_ALLOC;
        req_bus.is_qos_data = 1'b0;
        req_bus.dest_addr   = '0;
        req_bus.tid         = '0;
        rsp_bus.ready       = 1'b0;
        shared_next = '0;
        for (int s = 0; s < wtsa_pkg::STATIONS; s++)
        begin
            sta_used[s] = 1'b0;
            sta_addr[s] = '0;
            for (int k = 0; k < wtsa_pkg::TIDS; k++)
                sta_next[s][k] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_shared_counter();
        test_station_table();
        test_counter_run();
        test_random_traffic();

        req_bus.valid <= 1'b0;
        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d request words, checked %0d responses, %0d with table_full.",
                 words_sent, responses_seen, full_seen);
        $display("Covered shared and per-station counters, a long allocate run, peek, ",
                 "query, unused code and a full station table.");
        if (mismatches == 0 && expected_numbers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
